@@ hdl/fbpa_pkg.sv @@
package fbpa_pkg;

   localparam int IDX_W        = 8;
   localparam int COUNT_W      = 9;
   localparam int SIZE_W       = 13;
   localparam int ADDR_W       = 32;
   localparam int STATUS_W     = 2;
   localparam int LINK_DEPTH   = 256;
   localparam int MAX_BLOCKS_DEF = 256;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd32;
   localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd0;

   typedef enum logic [1:0] {
      REG_BLOCK_COUNT = 2'd0,
      REG_BLOCK_SIZE  = 2'd1,
      REG_POOL_BASE   = 2'd2
   } reg_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic {
      MODE_ALLOC   = 1'b0,
      MODE_RELEASE = 1'b1
   } mode_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_RESP = 1'b1
   } fsm_type;

   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic             clear;
      logic [IDX_W-1:0] addr;
      logic [IDX_W-1:0] wdata;
   } link_req_type;

   // clamp the written count to 2 .. lim
   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n,
                                                      input logic [COUNT_W-1:0] lim);
      logic [COUNT_W-1:0] r;
      r = n;
      if (r > lim) r = lim;
      if (r < 9'd2) r = 9'd2;
      return r;
   endfunction

endpackage

@@ hdl/fbpa_link_mem.sv @@
module fbpa_link_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  fbpa_pkg::link_req_type        req,
   output logic [fbpa_pkg::IDX_W-1:0]    rd_link
);

   logic [fbpa_pkg::IDX_W-1:0]      mem [fbpa_pkg::LINK_DEPTH];
   logic [fbpa_pkg::LINK_DEPTH-1:0] valid_ff;
   logic [fbpa_pkg::IDX_W-1:0]      rdata_ff;
   logic [fbpa_pkg::IDX_W-1:0]      raddr_ff;
   logic                            rvalid_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd_en) begin
         rdata_ff  <= mem[req.addr];
         raddr_ff  <= req.addr;
         rvalid_ff <= valid_ff[req.addr];
      end
   end

   // an entry never written since the last rebuild links to its successor
   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.addr] <= 1'b1;
      end
   end

   assign rd_link = rvalid_ff ? rdata_ff : raddr_ff + 8'd1;

endmodule

@@ hdl/fbpa_ctrl.sv @@
module fbpa_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rebuild,
   input  logic [fbpa_pkg::COUNT_W-1:0]      eff_count_in,
   input  logic [fbpa_pkg::COUNT_W-1:0]      eff_count,
   input  logic [fbpa_pkg::SIZE_W-1:0]       block_size,
   input  logic [fbpa_pkg::ADDR_W-1:0]       pool_base,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_mode,
   input  logic [fbpa_pkg::IDX_W-1:0]        req_index,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fbpa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fbpa_pkg::IDX_W-1:0]        rsp_index,
   output logic [fbpa_pkg::ADDR_W-1:0]       rsp_addr,
   output logic [fbpa_pkg::COUNT_W-1:0]      rsp_free,
   output fbpa_pkg::link_req_type            link_req,
   input  logic [fbpa_pkg::IDX_W-1:0]        rd_link
);

   fbpa_pkg::fsm_type state_ff, state_in;

   logic [fbpa_pkg::IDX_W-1:0]    head_ff;
   logic [fbpa_pkg::COUNT_W-1:0]  free_ff;
   logic                          mode_ff;
   logic [fbpa_pkg::IDX_W-1:0]    idx_ff;

   logic                          rsp_valid_ff;
   logic [fbpa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [fbpa_pkg::IDX_W-1:0]    rsp_index_ff;
   logic [fbpa_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [fbpa_pkg::COUNT_W-1:0]  rsp_free_ff;

   logic                          accept;
   logic                          load;
   logic                          alloc_ok;
   logic                          rel_ok;
   logic [20:0]                   prod;
   logic [fbpa_pkg::STATUS_W-1:0] status_in;
   logic [fbpa_pkg::IDX_W-1:0]    head_in;
   logic [fbpa_pkg::COUNT_W-1:0]  free_in;
   logic [fbpa_pkg::IDX_W-1:0]    gidx_in;
   logic [fbpa_pkg::ADDR_W-1:0]   gaddr_in;

   assign req_tready = (state_ff == fbpa_pkg::FSM_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign alloc_ok   = (free_ff != '0);
   assign rel_ok     = (free_ff < eff_count);
   assign prod       = 21'(head_ff) * 21'(block_size);

   // pop reads the head's link, push writes the old head into the released entry
   always_comb begin
      link_req.rd_en = accept && (req_mode == fbpa_pkg::MODE_ALLOC);
      link_req.wr_en = accept && (req_mode == fbpa_pkg::MODE_RELEASE) && rel_ok;
      link_req.clear = rebuild;
      link_req.addr  = (req_mode == fbpa_pkg::MODE_ALLOC) ? head_ff : req_index;
      link_req.wdata = head_ff;
   end

   always_comb begin
      state_in  = state_ff;
      load      = 1'b0;
      status_in = fbpa_pkg::ST_OK;
      head_in   = head_ff;
      free_in   = free_ff;
      gidx_in   = '0;
      gaddr_in  = '0;
      if (mode_ff == fbpa_pkg::MODE_ALLOC) begin
         if (alloc_ok) begin
            head_in  = rd_link;
            free_in  = free_ff - 9'd1;
            gidx_in  = head_ff;
            gaddr_in = pool_base + 32'(prod);
         end else begin
            status_in = fbpa_pkg::ST_NO_FREE;
         end
      end else begin
         if (rel_ok) begin
            head_in = idx_ff;
            free_in = free_ff + 9'd1;
         end else begin
            status_in = fbpa_pkg::ST_FULL;
         end
      end
      case (state_ff)
         fbpa_pkg::FSM_IDLE: begin
            if (accept) state_in = fbpa_pkg::FSM_RESP;
         end
         fbpa_pkg::FSM_RESP: begin
            // hold while the previous result is still waiting
            if (!rsp_valid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = fbpa_pkg::FSM_IDLE;
            end
         end
         default: state_in = fbpa_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbpa_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || rebuild) begin
         head_ff <= '0;
         free_ff <= eff_count_in;
      end else if (load) begin
         head_ff <= head_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         idx_ff  <= req_index;
      end
      if (load) begin
         rsp_status_ff <= status_in;
         rsp_index_ff  <= gidx_in;
         rsp_addr_ff   <= gaddr_in;
         rsp_free_ff   <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_free   = rsp_free_ff;

   a_accept_then_resp: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == fbpa_pkg::FSM_RESP))
      else $error("accepted beat did not move to response");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(link_req.rd_en && link_req.wr_en))
      else $error("link memory read and write in one cycle");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fbpa_pkg::FSM_IDLE) |-> (free_ff <= eff_count))
      else $error("free count above pool size");

   a_alloc_dec: assert property (@(posedge clock) disable iff (reset || rebuild)
      (load && mode_ff == fbpa_pkg::MODE_ALLOC && alloc_ok)
      |=> (free_ff == $past(free_ff) - 9'd1))
      else $error("allocate did not take one block");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("result lost");

endmodule

@@ hdl/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator with a linked free list.
// Request channel (req_): tuser carries the mode (0 allocate, 1 release),
// tdata the block index to release. Result channel (rsp_): tuser carries the
// status (0 ok, 1 no free block, 2 pool already full), tdata the granted index,
// granted byte address and the free count after the request.
// Configuration: csr_we, csr_index and csr_wdata write block_count, block_size
// or pool_base; any such write makes every block free again, linked in
// ascending order. Write only while the block is idle.
// Per request, the accept cycle issues the link memory access; the response
// step then uses the registered read data to update the head and load the
// result register. A new request is taken only once the previous one has
// loaded its result; the loop through the registered link memory read sets
// this. A result is visible once loaded. The next request is
// accepted while a result waits; if the receiver stalls, that following request
// holds in its response step until the result register is taken.
// Reset is synchronous: all blocks free, head at block zero, no result pending.
// No clearing pass is needed; per-entry valid bits clear at once.
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] block_index
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] granted_index, [39:8] granted_address,
                                    // [48:40] free_count, [55:49] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int LIM = (MAX_BLOCKS > fbpa_pkg::LINK_DEPTH) ? fbpa_pkg::LINK_DEPTH
                                                            : MAX_BLOCKS;
   localparam logic [fbpa_pkg::COUNT_W-1:0] LIM_C = fbpa_pkg::COUNT_W'(LIM);

   logic [fbpa_pkg::COUNT_W-1:0] eff_count_ff, eff_count_in;
   logic [fbpa_pkg::SIZE_W-1:0]  block_size_ff;
   logic [fbpa_pkg::ADDR_W-1:0]  pool_base_ff;
   logic                         rebuild;
   fbpa_pkg::link_req_type       link_req;
   logic [fbpa_pkg::IDX_W-1:0]   rd_link;
   logic [fbpa_pkg::IDX_W-1:0]   rsp_index;
   logic [fbpa_pkg::ADDR_W-1:0]  rsp_addr;
   logic [fbpa_pkg::COUNT_W-1:0] rsp_free;

   always_comb begin
      rebuild      = 1'b0;
      eff_count_in = eff_count_ff;
      if (reset) begin
         eff_count_in = fbpa_pkg::clamp_count(fbpa_pkg::COUNT_RESET, LIM_C);
      end else if (csr_we) begin
         case (csr_index)
            fbpa_pkg::REG_BLOCK_COUNT: begin
               rebuild      = 1'b1;
               eff_count_in = fbpa_pkg::clamp_count(csr_wdata[8:0], LIM_C);
            end
            fbpa_pkg::REG_BLOCK_SIZE:  rebuild = 1'b1;
            fbpa_pkg::REG_POOL_BASE:   rebuild = 1'b1;
            default:                   rebuild = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_count_ff  <= eff_count_in;
         block_size_ff <= fbpa_pkg::SIZE_RESET;
         pool_base_ff  <= fbpa_pkg::BASE_RESET;
      end else begin
         eff_count_ff <= eff_count_in;
         if (csr_we && csr_index == fbpa_pkg::REG_BLOCK_SIZE) begin
            block_size_ff <= csr_wdata[12:0];
         end
         if (csr_we && csr_index == fbpa_pkg::REG_POOL_BASE) begin
            pool_base_ff <= csr_wdata;
         end
      end
   end

   fbpa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .rebuild      (rebuild),
      .eff_count_in (eff_count_in),
      .eff_count    (eff_count_ff),
      .block_size   (block_size_ff),
      .pool_base    (pool_base_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_mode     (req_tuser),
      .req_index    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (rsp_tuser),
      .rsp_index    (rsp_index),
      .rsp_addr     (rsp_addr),
      .rsp_free     (rsp_free),
      .link_req     (link_req),
      .rd_link      (rd_link)
   );

   fbpa_link_mem u_link_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (link_req),
      .rd_link (rd_link)
   );

   assign rsp_tdata = {7'd0, rsp_free, rsp_addr, rsp_index};

endmodule
